/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the rtl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define SBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SBA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/sba_pkg.sv */
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants of the sector bitmap allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int BITS_PER_WORD   = 8;
  localparam int WORD_IDX_W      = 3;
  localparam int MAX_SECTORS_DEF = 2048;

  localparam int OP_W     = 3;
  localparam int SECTOR_W = 11;
  localparam int COUNT_W  = 12;
  localparam int SCOUNT_W = 12;

  localparam logic [SCOUNT_W-1:0] SCOUNT_RST = 12'd2048;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 3'd0,
    OP_FIND  = 3'd1,
    OP_ALLOC = 3'd2,
    OP_FREE  = 3'd3,
    OP_SYNC  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;

  // request to the word unit
  typedef struct packed {
    logic                  rem_ge_word;
    logic [WORD_IDX_W-1:0] rem_low;
    logic [WORD_IDX_W-1:0] lo;
  } word_req_t;

  // answer of the word unit
  typedef struct packed {
    logic [BITS_PER_WORD-1:0] mask;
    logic                     any_free;
    logic [WORD_IDX_W-1:0]    first_idx;
  } word_res_t;

endpackage

/* hdl/sba_bitmap_ram.sv */
// ----------------------------------------------------------------------------
// sba_bitmap_ram
// Bitmap store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sba_bitmap_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [sba_pkg::BITS_PER_WORD-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic [sba_pkg::BITS_PER_WORD-1:0] rd_data
);
  import sba_pkg::*;

  logic [BITS_PER_WORD-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sba_word_unit.sv */
// ----------------------------------------------------------------------------
// sba_word_unit
// Range mask and first free bit of one bitmap word.
// ----------------------------------------------------------------------------
module sba_word_unit (
  input  logic [sba_pkg::BITS_PER_WORD-1:0] word,
  input  sba_pkg::word_req_t                req,
  output sba_pkg::word_res_t                res
);
  import sba_pkg::*;

  logic [BITS_PER_WORD-1:0] mask;
  logic [BITS_PER_WORD-1:0] free_bits;
  logic [WORD_IDX_W-1:0]    first_idx;

  always_comb begin
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      mask[i] = (WORD_IDX_W'(i) >= req.lo) &&
                (req.rem_ge_word || (WORD_IDX_W'(i) < req.rem_low));
    end
  end

  assign free_bits = ~word & mask;

  // lowest free bit wins
  always_comb begin
    first_idx = '0;
    for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        first_idx = WORD_IDX_W'(i);
      end
    end
  end

  assign res.mask      = mask;
  assign res.any_free  = |free_bits;
  assign res.first_idx = first_idx;

endmodule

/* hdl/sector_bitmap_allocator.sv */
// Sector bitmap allocator: one bit per sector (set = used) in a byte-wide
// store, plus a dirty mark. After reset the block first clears the store,
// one byte per cycle, and takes no request until that pass ends;
// configuration writes are taken at any time. One request is served at a
// time. Search, allocate and free walk the store one byte at a time (read,
// then evaluate or write back). The result sits in an output register, and
// the next request is taken while it waits.
// ----------------------------------------------------------------------------
// sector_bitmap_allocator
// Free-space bitmap with query, search, allocate run, free run and sync.
// ----------------------------------------------------------------------------
module sector_bitmap_allocator #(
  parameter int MAX_SECTORS = sba_pkg::MAX_SECTORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sba_pkg::SCOUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sba_pkg::OP_W-1:0]     op,
  input  logic [sba_pkg::SECTOR_W-1:0] sector,
  input  logic [sba_pkg::COUNT_W-1:0]  count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         is_free,
  output logic                         found,
  output logic [sba_pkg::SECTOR_W-1:0] found_sector,
  output logic                         flush_needed
);
  import sba_pkg::*;

  localparam int STORE_WORDS = (MAX_SECTORS + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int SW = $clog2(MAX_SECTORS + 1);
  localparam int PW = ((SW > COUNT_W) ? SW : COUNT_W) + 1;
  localparam logic [PW-1:0] MAX_P     = PW'(MAX_SECTORS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  state_t                   state, state_next;
  logic [AW-1:0]            clr_addr, clr_addr_next;
  logic [PW-1:0]            pos, pos_next;
  logic [PW-1:0]            lim, lim_next;
  op_t                      cur_op, cur_op_next;
  logic                     dirty, dirty_next;
  logic [SCOUNT_W-1:0]      sector_count;
  logic                     res_is_free, res_is_free_next;
  logic                     res_found, res_found_next;
  logic [SECTOR_W-1:0]      res_sector, res_sector_next;
  logic                     res_flush, res_flush_next;
  logic                     load_out;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [BITS_PER_WORD-1:0] wr_data;
  logic                     rd_en;
  logic [BITS_PER_WORD-1:0] rd_data;

  logic [PW-1:0]            sector_pos;
  logic [PW-1:0]            bound;
  logic [PW-1:0]            run_sum;
  logic [PW-1:0]            run_end;
  logic [PW-1:0]            base;
  logic [PW-1:0]            adv_pos;
  logic [PW-1:0]            rem;
  logic [PW-1:0]            hit_pos;
  logic [AW-1:0]            word_addr;
  word_req_t                wreq;
  word_res_t                wres;

  sba_bitmap_ram #(
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (word_addr),
    .rd_data (rd_data)
  );

  sba_word_unit u_word (
    .word (rd_data),
    .req  (wreq),
    .res  (wres)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  assign sector_pos = PW'(sector);
  assign bound      = (PW'(sector_count) < MAX_P) ? PW'(sector_count) : MAX_P;
  assign run_sum    = sector_pos + PW'(count);
  assign run_end    = (run_sum < MAX_P) ? run_sum : MAX_P;

  assign word_addr  = pos[AW+WORD_IDX_W-1:WORD_IDX_W];
  assign base       = {pos[PW-1:WORD_IDX_W], WORD_IDX_W'(0)};
  assign adv_pos    = base + PW'(BITS_PER_WORD);
  assign rem        = lim - base;
  assign hit_pos    = base + PW'(wres.first_idx);

  assign wreq.rem_ge_word = (rem >= PW'(BITS_PER_WORD));
  assign wreq.rem_low     = rem[WORD_IDX_W-1:0];
  assign wreq.lo          = pos[WORD_IDX_W-1:0];

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    pos_next         = pos;
    lim_next         = lim;
    cur_op_next      = cur_op;
    dirty_next       = dirty;
    res_is_free_next = res_is_free;
    res_found_next   = res_found;
    res_sector_next  = res_sector;
    res_flush_next   = res_flush;
    load_out         = 1'b0;
    wr_en            = 1'b0;
    wr_addr          = word_addr;
    wr_data          = '0;
    rd_en            = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          res_is_free_next = 1'b0;
          res_found_next   = 1'b0;
          res_sector_next  = '0;
          res_flush_next   = 1'b0;
          pos_next         = sector_pos;
          cur_op_next      = op_t'(op);
          state_next       = ST_DONE;
          unique case (op_t'(op))
            OP_QUERY: begin
              if (sector_pos < MAX_P) begin
                state_next = ST_READ;
              end
            end
            OP_FIND: begin
              lim_next = bound;
              if (sector_pos < bound) begin
                state_next = ST_READ;
              end
            end
            OP_ALLOC, OP_FREE: begin
              dirty_next = 1'b1;
              lim_next   = run_end;
              if (sector_pos < run_end) begin
                state_next = ST_READ;
              end
            end
            OP_SYNC: begin
              res_flush_next = dirty;
              dirty_next     = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        rd_en      = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cur_op)
          OP_QUERY: begin
            res_is_free_next = ~rd_data[pos[WORD_IDX_W-1:0]];
            state_next       = ST_DONE;
          end
          OP_FIND: begin
            if (wres.any_free) begin
              res_found_next  = 1'b1;
              res_sector_next = hit_pos[SECTOR_W-1:0];
              state_next      = ST_DONE;
            end else if (adv_pos >= lim) begin
              state_next = ST_DONE;
            end else begin
              pos_next   = adv_pos;
              state_next = ST_READ;
            end
          end
          OP_ALLOC, OP_FREE: begin
            wr_en   = 1'b1;
            wr_data = (cur_op == OP_ALLOC) ? (rd_data | wres.mask) : (rd_data & ~wres.mask);
            if (adv_pos >= lim) begin
              state_next = ST_DONE;
            end else begin
              pos_next   = adv_pos;
              state_next = ST_READ;
            end
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      dirty    <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      dirty    <= dirty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_count <= SCOUNT_RST;
    end else if (cfg_valid) begin
      sector_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    lim         <= lim_next;
    cur_op      <= cur_op_next;
    res_is_free <= res_is_free_next;
    res_found   <= res_found_next;
    res_sector  <= res_sector_next;
    res_flush   <= res_flush_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      is_free      <= res_is_free;
      found        <= res_found;
      found_sector <= res_sector;
      flush_needed <= res_flush;
    end
  end

  `include "assert_macros.svh"

  `SBA_ASSERT_ALWAYS(a_no_req_in_clear,
                     (state == ST_CLEAR) |-> !in_ready,
                     "request taken during clear pass")
  `SBA_ASSERT(a_walk_in_range,
              (state == ST_READ && cur_op != OP_QUERY) |-> (pos < lim),
              "walk position past its limit")
  `SBA_ASSERT(a_write_only_runs,
              (wr_en && state == ST_EXEC) |-> (cur_op == OP_ALLOC || cur_op == OP_FREE),
              "store written by a non-run request")
  `SBA_ASSERT(a_result_held,
              (state == ST_DONE && out_valid && !out_ready) |=> (state == ST_DONE),
              "result overwrote a pending one")
  `SBA_ASSERT(a_sync_clears,
              (in_valid && in_ready && op == OP_SYNC) |=> !dirty,
              "sync left dirty mark set")

endmodule

/* sim/sba_answer_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_answer_checker
// Watches the request, answer and configuration channels of the sector bitmap
// allocator, keeps its own copy of the sector map, dirty mark and sector
// count, works out the answer of every request and compares it with what the
// block returns, in order.
// ----------------------------------------------------------------------------
module sba_answer_checker #(
  parameter int MAX_SECTORS = sba_pkg::MAX_SECTORS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [sba_pkg::SCOUNT_W-1:0] cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [sba_pkg::OP_W-1:0]     op,
  input  logic [sba_pkg::SECTOR_W-1:0] sector,
  input  logic [sba_pkg::COUNT_W-1:0]  count,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         is_free,
  input  logic                         found,
  input  logic [sba_pkg::SECTOR_W-1:0] found_sector,
  input  logic                         flush_needed,
  output int                           mismatches,
  output int                           pending
);
  import sba_pkg::*;

  typedef struct packed {
    logic                is_free;
    logic                found;
    logic [SECTOR_W-1:0] found_sector;
    logic                flush_needed;
  } answer_t;

  logic [MAX_SECTORS-1:0] used_map;
  logic                   map_dirty;
  logic [SCOUNT_W-1:0]    search_limit;
  answer_t                pending_answers[$];
  int                     fail_count = 0;

  assign mismatches = fail_count;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  function automatic answer_t bitmap_answer(input logic [OP_W-1:0]     code,
                                            input logic [SECTOR_W-1:0] start,
                                            input logic [COUNT_W-1:0]  len);
    answer_t a;
    int      bound;
    int      stop;
    a = '0;
    case (code)
      OP_QUERY: begin
        if (int'(start) < MAX_SECTORS) a.is_free = !used_map[start];
      end
      OP_FIND: begin
        bound = (int'(search_limit) < MAX_SECTORS) ? int'(search_limit) : MAX_SECTORS;
        for (int s = int'(start); s < bound; s++) begin
          if (!used_map[s]) begin
            a.found        = 1'b1;
            a.found_sector = SECTOR_W'(s);
            break;
          end
        end
      end
      OP_ALLOC, OP_FREE: begin
        stop = int'(start) + int'(len);
        if (stop > MAX_SECTORS) stop = MAX_SECTORS;
        for (int s = int'(start); s < stop; s++) used_map[s] = (code == OP_ALLOC);
        map_dirty = 1'b1;
      end
      OP_SYNC: begin
        a.flush_needed = map_dirty;
        map_dirty      = 1'b0;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      used_map     = '0;
      map_dirty    = 1'b0;
      search_limit = SCOUNT_RST;
      pending_answers.delete();
    end else begin
      if (cfg_valid && cfg_ready) search_limit = cfg_data;
      if (out_valid && out_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("answer with no request outstanding");
        end else begin
          want = pending_answers.pop_front();
          if (is_free !== want.is_free)
            report_mismatch($sformatf("is_free %b, expected %b", is_free, want.is_free));
          if (found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found, want.found));
          if (found_sector !== want.found_sector)
            report_mismatch($sformatf("found_sector %0d, expected %0d",
                                      found_sector, want.found_sector));
          if (flush_needed !== want.flush_needed)
            report_mismatch($sformatf("flush_needed %b, expected %b",
                                      flush_needed, want.flush_needed));
        end
      end
      if (in_valid && in_ready) pending_answers.push_back(bitmap_answer(op, sector, count));
    end
    pending <= pending_answers.size();
  end

endmodule

/* sim/tb_sector_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sector_bitmap_allocator
// Drives the sector bitmap allocator with directed requests covering the
// edges of the map and every operation, then with random requests over
// several sector count settings, with random stalls on both channels. The
// answer checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_sector_bitmap_allocator;
  import sba_pkg::*;

  localparam int              STALL_LIMIT = 4000;
  localparam int              PHASE_ITEMS = 115;
  localparam int              NUM_PHASES  = 6;
  localparam logic [OP_W-1:0] OP_TOP      = '1;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [SCOUNT_W-1:0] cfg_data     = '0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op           = '0;
  logic [SECTOR_W-1:0] sector       = '0;
  logic [COUNT_W-1:0]  count        = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                is_free;
  logic                found;
  logic [SECTOR_W-1:0] found_sector;
  logic                flush_needed;

  int idle_pct    = 25;
  int stall_left  = 0;
  int idle_cycles = 0;
  int mismatches;
  int pending;

  sector_bitmap_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .sector       (sector),
    .count        (count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_free      (is_free),
    .found        (found),
    .found_sector (found_sector),
    .flush_needed (flush_needed)
  );

  sba_answer_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .sector       (sector),
    .count        (count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_free      (is_free),
    .found        (found),
    .found_sector (found_sector),
    .flush_needed (flush_needed),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always #5 clk = ~clk;

  // answer side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      stall_left <= $urandom_range(0, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_W-1:0] code, input int start, input int len);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    sector   <= SECTOR_W'(start);
    count    <= COUNT_W'(len);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_request();
    int              pick;
    int              start;
    int              len;
    logic [OP_W-1:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 20) code = OP_QUERY;
    else if (pick < 45) code = OP_FIND;
    else if (pick < 63) code = OP_ALLOC;
    else if (pick < 81) code = OP_FREE;
    else if (pick < 93) code = OP_SYNC;
    else code = OP_W'($urandom_range(OP_SYNC + 1, OP_TOP));
    pick = $urandom_range(0, 99);
    if (pick < 70) start = $urandom_range(0, 255);
    else if (pick < 90) start = $urandom_range(0, 2047);
    else start = $urandom_range(1900, 2047);
    pick = $urandom_range(0, 99);
    if (pick < 60) len = $urandom_range(0, 16);
    else if (pick < 85) len = $urandom_range(17, 96);
    else if (pick < 95) len = $urandom_range(0, 2048);
    else len = $urandom_range(2049, 4095);
    send_request(code, start, len);
  endtask

  // lowers the request line, then waits for every answer to come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_sector_count(input logic [SCOUNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SCOUNT_W-1:0] limits[NUM_PHASES];
    int                  pcts[NUM_PHASES];
    limits = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(2, 2047)), SCOUNT_RST,
               12'($urandom_range(0, 4095))};
    pcts   = '{25, 10, 40, 0, 25, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_QUERY, 0, 0);
    send_request(OP_QUERY, 2047, 4095);
    send_request(OP_FIND, 0, 0);
    send_request(OP_FIND, 2047, 0);
    send_request(OP_SYNC, 0, 0);
    send_request(OP_ALLOC, 0, 0);
    send_request(OP_SYNC, 0, 0);
    send_request(OP_SYNC, 0, 0);
    send_request(OP_ALLOC, 2040, 2048);
    send_request(OP_QUERY, 2047, 0);
    send_request(OP_FIND, 2040, 0);
    send_request(OP_ALLOC, 0, 4095);
    send_request(OP_FIND, 0, 0);
    send_request(OP_FREE, 5, 1);
    send_request(OP_FIND, 0, 0);
    send_request(OP_QUERY, 5, 0);
    send_request(OP_FREE, 0, 2048);
    for (int c = OP_SYNC + 1; c <= OP_TOP; c++) send_request(OP_W'(c), 2047, 4095);
    send_request(OP_ALLOC, 1365, 2730);
    send_request(OP_FREE, 682, 1365);
    send_request(OP_FIND, 0, 0);
    send_request(OP_QUERY, 1364, 0);
    send_request(OP_SYNC, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_sector_count(limits[p]);
      idle_pct <= pcts[p];
      repeat (PHASE_ITEMS) send_random_request();
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sector_bitmap_allocator.f */
+incdir+hdl
hdl/sba_pkg.sv
hdl/sba_bitmap_ram.sv
hdl/sba_word_unit.sv
hdl/sector_bitmap_allocator.sv
sim/sba_answer_checker.sv
sim/tb_sector_bitmap_allocator.sv
